// File: src/ctrl_alt_digit_chord_detector_unit_defines.svh
// ----------------------------------------------------------------------------
// Chord detector assertion macros
// Shared shorthand for the concurrent checks of the chord detector.
// ----------------------------------------------------------------------------
`ifndef CTRL_ALT_DIGIT_CHORD_DETECTOR_UNIT_DEFINES_SVH
`define CTRL_ALT_DIGIT_CHORD_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define CADCD_ASSERT_IMPL(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("chord detector check failed");

// Next-cycle implication, off while reset is asserted.
`define CADCD_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("chord detector check failed");

`endif

// File: src/cadcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chord detector package
// Types, register indexes and state codes shared by the chord detector.
// ----------------------------------------------------------------------------
package cadcd_pkg;

	localparam int KEY_W  = 8;
	localparam int CFG_IW = 3;

	// Configuration register indexes
	localparam logic [CFG_IW-1:0] REG_CTRL_LEFT   = 3'd0;
	localparam logic [CFG_IW-1:0] REG_CTRL_RIGHT  = 3'd1;
	localparam logic [CFG_IW-1:0] REG_ALT_LEFT    = 3'd2;
	localparam logic [CFG_IW-1:0] REG_ALT_RIGHT   = 3'd3;
	localparam logic [CFG_IW-1:0] REG_DIGIT_FIRST = 3'd4;
	localparam logic [CFG_IW-1:0] REG_DIGIT_LAST  = 3'd5;

	// Register reset values
	localparam logic [KEY_W-1:0] RST_CTRL_LEFT   = 8'h1d;
	localparam logic [KEY_W-1:0] RST_CTRL_RIGHT  = 8'h61;
	localparam logic [KEY_W-1:0] RST_ALT_LEFT    = 8'h38;
	localparam logic [KEY_W-1:0] RST_ALT_RIGHT   = 8'h64;
	localparam logic [KEY_W-1:0] RST_DIGIT_FIRST = 8'h02;
	localparam logic [KEY_W-1:0] RST_DIGIT_LAST  = 8'h0b;

	// Chord machine codes, as seen on chord_state
	localparam logic [2:0] CH_EMPTY = 3'd0;
	localparam logic [2:0] CH_CTRL  = 3'd1;
	localparam logic [2:0] CH_ALT   = 3'd2;
	localparam logic [2:0] CH_BOTH  = 3'd3;
	localparam logic [2:0] CH_WAIT  = 3'd4;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_FIN
	} cadcd_state_t;

	typedef enum logic [1:0] {
		RES_IGNORE,
		RES_OVF,
		RES_STEP
	} cadcd_res_t;

	typedef struct packed {
		logic       capture;
		logic       scan;
		logic       shift_start;
		logic       shift;
		logic       push;
		logic       pop;
		logic       finish;
		cadcd_res_t res;
	} cadcd_cmd_t;

	typedef struct packed {
		logic trivial;
		logic is_press;
		logic hit;
		logic miss_done;
		logic shift_done;
		logic full;
		logic out_free;
	} cadcd_status_t;

endpackage

// File: src/cadcd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chord detector channels
// Keyboard event channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cadcd_in_if;
	logic       valid;
	logic       ready;
	logic       event_kind;
	logic       key_down;
	logic [7:0] key_code;

	modport source (output valid, output event_kind, output key_down, output key_code,
		input ready);
	modport sink (input valid, input event_kind, input key_down, input key_code,
		output ready);
endinterface

interface cadcd_out_if;
	logic       valid;
	logic       ready;
	logic       switch_fire;
	logic [7:0] switch_target;
	logic [2:0] chord_state;
	logic [3:0] held_count;
	logic       event_used;
	logic       list_overflow;

	modport source (output valid, output switch_fire, output switch_target,
		output chord_state, output held_count, output event_used, output list_overflow,
		input ready);
	modport sink (input valid, input switch_fire, input switch_target,
		input chord_state, input held_count, input event_used, input list_overflow,
		output ready);
endinterface

// File: src/cadcd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chord detector controller
// Sequences capture, held-list scan, compaction and result load.
// ----------------------------------------------------------------------------
module cadcd_ctrl
	import cadcd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cadcd_status_t status,
	output cadcd_cmd_t    cmd
);

	cadcd_state_t state_q, state_d;
	cadcd_res_t   res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= RES_IGNORE;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		res_d    = res_q;
		cmd      = '0;
		cmd.res  = res_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_SCAN;
				end
			end
			S_SCAN: begin
				if (status.trivial) begin
					res_d   = RES_IGNORE;
					state_d = S_FIN;
				end else begin
					cmd.scan = 1'b1;
					if (status.hit) begin
						if (status.is_press) begin
							// duplicate press
							res_d   = RES_IGNORE;
							state_d = S_FIN;
						end else begin
							cmd.shift_start = 1'b1;
							state_d         = S_SHIFT;
						end
					end else if (status.miss_done) begin
						if (!status.is_press) begin
							// release of an unheld key still steps the machine
							res_d   = RES_STEP;
							state_d = S_FIN;
						end else if (status.full) begin
							res_d   = RES_OVF;
							state_d = S_FIN;
						end else begin
							cmd.push = 1'b1;
							res_d    = RES_STEP;
							state_d  = S_FIN;
						end
					end
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (status.shift_done) begin
					cmd.pop = 1'b1;
					res_d   = RES_STEP;
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: src/cadcd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chord detector datapath
// Held-key list, count, chord register, config registers, result register.
// ----------------------------------------------------------------------------
`include "ctrl_alt_digit_chord_detector_unit_defines.svh"

module cadcd_dp
	import cadcd_pkg::*;
#(
	parameter int MAX_HELD = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [KEY_W-1:0]  cfg_data,
	input  logic              event_kind,
	input  logic              key_down,
	input  logic [KEY_W-1:0]  key_code,
	input  cadcd_cmd_t        cmd,
	output cadcd_status_t     status,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              switch_fire,
	output logic [KEY_W-1:0]  switch_target,
	output logic [2:0]        chord_state,
	output logic [3:0]        held_count,
	output logic              event_used,
	output logic              list_overflow
);

	localparam int AW = $clog2(MAX_HELD);
	localparam int CW = $clog2(MAX_HELD + 1);

	logic [KEY_W-1:0] mem [MAX_HELD];

	logic [KEY_W-1:0] ctrl_l_q, ctrl_r_q, alt_l_q, alt_r_q, dig_first_q, dig_last_q;
	logic             kind_q, down_q;
	logic [KEY_W-1:0] key_q;
	logic [CW-1:0]    total_q;
	logic [CW-1:0]    idx_q;
	logic             rd_vld_s1;
	logic [AW-1:0]    rd_idx_s1;
	logic [KEY_W-1:0] rd_data_s1;
	logic [2:0]       chord_q;
	logic             out_vld_q;

	logic             issue;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [KEY_W-1:0] wr_data;
	logic             key_ctrl, key_alt, key_digit;
	logic [2:0]       chord_next;
	logic             fire;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_l_q    <= RST_CTRL_LEFT;
			ctrl_r_q    <= RST_CTRL_RIGHT;
			alt_l_q     <= RST_ALT_LEFT;
			alt_r_q     <= RST_ALT_RIGHT;
			dig_first_q <= RST_DIGIT_FIRST;
			dig_last_q  <= RST_DIGIT_LAST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CTRL_LEFT:   ctrl_l_q    <= cfg_data;
				REG_CTRL_RIGHT:  ctrl_r_q    <= cfg_data;
				REG_ALT_LEFT:    alt_l_q     <= cfg_data;
				REG_ALT_RIGHT:   alt_r_q     <= cfg_data;
				REG_DIGIT_FIRST: dig_first_q <= cfg_data;
				REG_DIGIT_LAST:  dig_last_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Captured event
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= event_kind;
			down_q <= key_down;
			key_q  <= key_code;
		end
	end

	// Walk one list entry per cycle; read data is registered and lands in the next cycle
	assign issue = (cmd.scan || cmd.shift) && (idx_q < total_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else if (cmd.capture) begin
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else if (cmd.shift_start) begin
			idx_q     <= CW'(rd_idx_s1) + CW'(1);
			rd_vld_s1 <= 1'b0;
		end else begin
			if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			rd_vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_idx_s1 <= idx_q[AW-1:0];
		end
	end

	// Held-key memory: one write and one registered read a cycle
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = total_q[AW-1:0];
		wr_data = key_q;
		if (cmd.shift && rd_vld_s1) begin
			// move the entry down over the released key
			wr_en   = 1'b1;
			wr_addr = rd_idx_s1 - AW'(1);
			wr_data = rd_data_s1;
		end else if (cmd.push) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (issue) begin
			rd_data_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.push) begin
			total_q <= total_q + CW'(1);
		end else if (cmd.pop) begin
			total_q <= total_q - CW'(1);
		end
	end

	// Chord machine step
	assign key_ctrl  = (key_q == ctrl_l_q) || (key_q == ctrl_r_q);
	assign key_alt   = (key_q == alt_l_q) || (key_q == alt_r_q);
	assign key_digit = (key_q >= dig_first_q) && (key_q <= dig_last_q);

	always_comb begin
		chord_next = CH_WAIT;
		fire       = 1'b0;
		case (chord_q)
			CH_EMPTY: begin
				if (key_ctrl) begin
					chord_next = CH_CTRL;
				end else if (key_alt) begin
					chord_next = CH_ALT;
				end
			end
			CH_CTRL: if (key_alt) chord_next = CH_BOTH;
			CH_ALT:  if (key_ctrl) chord_next = CH_BOTH;
			CH_BOTH: fire = key_digit;
			CH_WAIT: if (total_q == '0) chord_next = CH_EMPTY;
			default: chord_next = CH_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chord_q <= CH_EMPTY;
		end else if (cmd.finish && cmd.res == RES_STEP) begin
			chord_q <= chord_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.finish) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			switch_fire   <= (cmd.res == RES_STEP) && fire;
			switch_target <= ((cmd.res == RES_STEP) && fire) ? (key_q - dig_first_q) : '0;
			chord_state   <= (cmd.res == RES_STEP) ? chord_next : chord_q;
			held_count    <= 4'(total_q);
			event_used    <= (cmd.res == RES_STEP);
			list_overflow <= (cmd.res == RES_OVF);
		end
	end

	assign out_valid = out_vld_q;

	assign status.trivial    = !kind_q || (!down_q && (total_q == '0));
	assign status.is_press   = down_q;
	assign status.hit        = rd_vld_s1 && (rd_data_s1 == key_q);
	assign status.miss_done  = !rd_vld_s1 && (idx_q >= total_q);
	assign status.shift_done = !rd_vld_s1 && (idx_q >= total_q);
	assign status.full       = (total_q == CW'(MAX_HELD));
	assign status.out_free   = !out_vld_q || out_ready;

	`CADCD_ASSERT_IMPL(a_total_bound, clk, arst_n, 1'b1, total_q <= CW'(MAX_HELD))
	`CADCD_ASSERT_IMPL(a_shift_addr, clk, arst_n, cmd.shift && rd_vld_s1, rd_idx_s1 != '0)
	`CADCD_ASSERT_NEXT(a_push_grows, clk, arst_n, cmd.push, total_q == $past(total_q) + CW'(1))

endmodule

// File: src/ctrl_alt_digit_chord_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ctrl-Alt-digit chord detector
// Tracks held keys and fires a switch request on a Ctrl+Alt+digit chord.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries keyboard events (event_kind, key_down, key_code). An item
//          is taken when valid and ready are both high; ready is high only
//          while the sequencer is idle, so one event is in work at a time.
//   out_ch carries exactly one result item per event: fire flag and target,
//          chord state, held count, used and overflow flags.
//   cfg_*  writes one of six 8-bit keycode registers per cycle; write only
//          while no event is in work. Indexes beyond the list are dropped.
// Sequence: a non-key event, or a release into an empty list, goes from
//   capture straight to its final step; a press into an empty list is pushed
//   and then finishes. A scan walks the held entries and stops at a match or
//   at the end of the list; a release that matches then moves the later
//   entries down over it. The walk is paced by the single read port of the
//   held-key memory, one entry a cycle.
// Throughput: the next event is taken the cycle after a result is loaded,
//   even while that result still waits in the output register.
// Reset: clears the held count, the chord machine (empty), the sequencer and
//   the output valid; keycode registers return to their defaults.
// Stall: when out_ch is not ready, the finished result holds in the output
//   register and the next event waits at its final step until the slot frees.
// ----------------------------------------------------------------------------
module ctrl_alt_digit_chord_detector_unit
	import cadcd_pkg::*;
#(
	parameter int MAX_HELD = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	cadcd_in_if.sink          in_ch,
	cadcd_out_if.source       out_ch,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [KEY_W-1:0]  cfg_data
);

	cadcd_cmd_t    cmd;
	cadcd_status_t status;

	// Sequencer: capture, scan, compact, load result
	cadcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Held list, chord register, keycode registers and output register
	cadcd_dp #(
		.MAX_HELD (MAX_HELD)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.event_kind    (in_ch.event_kind),
		.key_down      (in_ch.key_down),
		.key_code      (in_ch.key_code),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.switch_fire   (out_ch.switch_fire),
		.switch_target (out_ch.switch_target),
		.chord_state   (out_ch.chord_state),
		.held_count    (out_ch.held_count),
		.event_used    (out_ch.event_used),
		.list_overflow (out_ch.list_overflow)
	);

endmodule
